// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the scanner unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property that holds on the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wbps_pkg.sv -----
`default_nettype none

package wbps_pkg;

    // Depth of the byte window
    localparam int PATTERN_MAX = 16;
    // Pattern positions that the registers can describe
    localparam int USABLE_LEN  = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
    localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
    localparam int PAT_IDX_W   = (USABLE_LEN > 1) ? $clog2(USABLE_LEN) : 1;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 48;
    localparam int INDEX_W     = 16;
    localparam int LEN_W       = 5;
    localparam int SEEN_W      = 17;

    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;

    // Register map, one register every 8 bytes
    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_SKIP         = 3'd4,
        REG_LIMIT        = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wildcard_byte_pattern_scanner_unit.sv -----
// Latency: a match is offered on m_tvalid the cycle after its byte transfer.
// Throughput: one byte per cycle; the window compare, the match counters and
// the address subtract all sit between the window registers and the result register.
// s_tready drops only while a result waits and m_tready is low.
// Reset (aresetn low, synchronous): window empty, counters zero, registers at
// their defaults (pattern length 1, match limit 1), no result pending.
`default_nettype none
`include "assert_macros.svh"

module wildcard_byte_pattern_scanner_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [wbps_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] data_byte, [55:8] byte_address
    input  wire logic                              s_tuser,  // [0] region_start
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [wbps_pkg::M_TDATA_W-1:0]         m_tdata,  // [47:0] match_address, [63:48] match_index
    output logic                                   m_tlast,  // limit_reached
    // Configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int PM = wbps_pkg::PATTERN_MAX;

    // Configuration registers
    logic [63:0]                      pat_low_reg;
    logic [63:0]                      pat_high_reg;
    logic [15:0]                      wild_reg;
    logic [wbps_pkg::LEN_W-1:0]       len_reg;
    logic [15:0]                      skip_reg;
    logic [15:0]                      limit_reg;

    // Scan state
    logic [wbps_pkg::DATA_W-1:0]      win_reg [PM];
    logic [wbps_pkg::DATA_W-1:0]      win_next [PM];
    logic [wbps_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic [wbps_pkg::SEEN_W-1:0]      seen_reg, seen_next;
    logic                             stopped_reg, stopped_next;

    // Result register
    logic                             out_valid_reg, out_valid_next;
    logic [wbps_pkg::ADDR_W-1:0]      out_addr_reg, out_addr_next;
    logic [wbps_pkg::INDEX_W-1:0]     out_index_reg, out_index_next;
    logic                             out_last_reg, out_last_next;

    logic                             in_xfer;
    logic                             cfg_wr;
    logic [wbps_pkg::DATA_W-1:0]      in_data;
    logic [wbps_pkg::ADDR_W-1:0]      in_addr;
    logic [127:0]                     pat_all;
    logic                             win_match;
    logic                             out_load;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign in_data  = s_tdata[7:0];
    assign in_addr  = s_tdata[55:8];
    assign pat_all  = {pat_high_reg, pat_low_reg};

    // Register reads
    always_comb begin
        case (wbps_pkg::cfg_reg_t'(paddr[5:3]))
            wbps_pkg::REG_PATTERN_LOW:  prdata = pat_low_reg;
            wbps_pkg::REG_PATTERN_HIGH: prdata = pat_high_reg;
            wbps_pkg::REG_WILDCARD:     prdata = {48'd0, wild_reg};
            wbps_pkg::REG_LENGTH:       prdata = {59'd0, len_reg};
            wbps_pkg::REG_SKIP:         prdata = {48'd0, skip_reg};
            wbps_pkg::REG_LIMIT:        prdata = {48'd0, limit_reg};
            default:                    prdata = '0;
        endcase
    end

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= wbps_pkg::LEN_W'(1);
            skip_reg     <= '0;
            limit_reg    <= 16'd1;
        end else if (cfg_wr && pready) begin
            case (wbps_pkg::cfg_reg_t'(paddr[5:3]))
                wbps_pkg::REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                wbps_pkg::REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                wbps_pkg::REG_WILDCARD:     wild_reg     <= pwdata[15:0];
                wbps_pkg::REG_LENGTH:       len_reg      <= pwdata[wbps_pkg::LEN_W-1:0];
                wbps_pkg::REG_SKIP:         skip_reg     <= pwdata[15:0];
                wbps_pkg::REG_LIMIT:        limit_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Window shift; a region start restarts the fill count
    always_comb begin
        win_next[0] = in_data;
        for (int k = 1; k < PM; k++) begin
            win_next[k] = win_reg[k-1];
        end
        if (s_tuser) begin
            fill_next = wbps_pkg::FILL_W'(1);
        end else if (fill_reg == wbps_pkg::FILL_W'(PM)) begin
            fill_next = fill_reg;
        end else begin
            fill_next = fill_reg + wbps_pkg::FILL_W'(1);
        end
    end

    // Compare each window position within the pattern length against its aligned pattern byte
    always_comb begin
        logic [wbps_pkg::LEN_W-1:0]     len_m1;
        logic [wbps_pkg::PAT_IDX_W-1:0] pidx;
        logic                           len_ok;
        logic                           fill_ok;
        logic                           bytes_ok;
        len_m1   = len_reg - wbps_pkg::LEN_W'(1);
        len_ok   = (len_reg != '0) && (len_reg <= wbps_pkg::LEN_W'(wbps_pkg::USABLE_LEN));
        fill_ok  = 32'(fill_next) >= 32'(len_reg);
        bytes_ok = 1'b1;
        pidx     = '0;
        for (int j = 0; j < wbps_pkg::USABLE_LEN; j++) begin
            if (wbps_pkg::LEN_W'(j) < len_reg) begin
                pidx = wbps_pkg::PAT_IDX_W'(len_m1 - wbps_pkg::LEN_W'(j));
                if (!wild_reg[pidx] && (win_next[j] != pat_all[8*pidx +: 8])) begin
                    bytes_ok = 1'b0;
                end
            end
        end
        win_match = len_ok && fill_ok && bytes_ok;
    end

    // Match counting, skip and limit
    always_comb begin
        logic [17:0] idx;
        logic [15:0] limit_eff;
        logic        last;
        seen_next      = seen_reg;
        stopped_next   = stopped_reg;
        out_load       = 1'b0;
        limit_eff      = (limit_reg == '0) ? 16'd1 : limit_reg;
        idx            = {1'b0, seen_reg} - {2'b00, skip_reg};
        last           = (idx + 18'd1) >= {2'b00, limit_eff};
        out_addr_next  = in_addr - wbps_pkg::ADDR_W'(len_reg - wbps_pkg::LEN_W'(1));
        out_index_next = idx[15:0];
        out_last_next  = last;
        if (in_xfer && win_match && !stopped_reg) begin
            if ({1'b0, seen_reg} < {2'b00, skip_reg}) begin
                seen_next = seen_reg + wbps_pkg::SEEN_W'(1);
            end else begin
                out_load = 1'b1;
                if (seen_reg != '1) begin
                    seen_next = seen_reg + wbps_pkg::SEEN_W'(1);
                end
                if (last) begin
                    stopped_next = 1'b1;
                end
            end
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            seen_reg      <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                fill_reg <= fill_next;
            end
            seen_reg      <= seen_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            for (int k = 0; k < PM; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
        if (out_load) begin
            out_addr_reg  <= out_addr_next;
            out_index_reg <= out_index_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

    // Checks
    `ASSERT_CLK(a_no_load_stopped, out_load |-> !stopped_reg, "result loaded after scan stop")
    `ASSERT_CLK(a_last_stops, (m_tvalid && m_tlast) |-> stopped_reg, "last result without stop")
    `ASSERT_NEXT(a_seen_mono, 1'b1, seen_reg >= $past(seen_reg), "match count went down")
    `ASSERT_CLK(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty result register")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT = 2000;
    // Register slots past the end of the map; writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                        start;
        logic [wbps_pkg::ADDR_W-1:0] addr;
        logic [wbps_pkg::DATA_W-1:0] data;
    } byte_item_t;

    typedef struct packed {
        logic [wbps_pkg::ADDR_W-1:0]  addr;
        logic [wbps_pkg::INDEX_W-1:0] idx;
        logic                         last;
    } match_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [wbps_pkg::S_TDATA_W-1:0]  s_tdata  = '0;  // [7:0] data_byte, [55:8] byte_address
    logic                            s_tuser  = 1'b0; // [0] region_start
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [wbps_pkg::M_TDATA_W-1:0]  m_tdata;  // [47:0] match_address, [63:48] match_index
    logic                            m_tlast;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [wbps_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    wildcard_byte_pattern_scanner_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the register file
    logic [63:0]                  pat_lo    = '0;
    logic [63:0]                  pat_hi    = '0;
    logic [15:0]                  wild_mask = '0;
    logic [wbps_pkg::LEN_W-1:0]   pat_len   = 5'd1;
    logic [15:0]                  skip_cnt  = '0;
    logic [15:0]                  limit_cnt = 16'd1;

    // Scanner state as the block should hold it
    logic [wbps_pkg::DATA_W-1:0]  win_bytes [wbps_pkg::PATTERN_MAX];
    int                           win_count   = 0;
    logic [wbps_pkg::SEEN_W-1:0]  match_count = '0;
    logic                         scan_done   = 1'b0;

    byte_item_t                   pending_q [$];
    match_t                       match_q   [$];
    logic [wbps_pkg::ADDR_W-1:0]  next_addr = '0;

    int errors       = 0;
    int bytes_in     = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int settings     = 0;

    initial begin
        foreach (win_bytes[k]) win_bytes[k] = '0;
    end

    function automatic logic [7:0] pat_byte(input int pos);
        logic [127:0] pat;
        pat = {pat_hi, pat_lo};
        return pat[8*pos +: 8];
    endfunction

    // Advance the window by one byte; returns 1 when a match is reported
    function automatic bit scan_byte(input byte_item_t it, output match_t hit);
        bit          ok;
        int          k;
        int unsigned idx;
        int unsigned lim;
        ok  = 1'b1;
        hit = '0;
        if (it.start) begin
            foreach (win_bytes[j]) win_bytes[j] = '0;
            win_count = 0;
        end
        for (k = wbps_pkg::PATTERN_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = it.data;
        if (win_count < wbps_pkg::PATTERN_MAX) win_count++;

        if (pat_len == 0 || pat_len > wbps_pkg::USABLE_LEN || win_count < pat_len) begin
            ok = 1'b0;
        end else begin
            for (k = 0; k < pat_len; k++)
                if (!wild_mask[k] && win_bytes[pat_len-1-k] != pat_byte(k)) ok = 1'b0;
        end
        if (scan_done || !ok) return 1'b0;

        // leading matches are counted but not reported
        if (match_count < skip_cnt) begin
            match_count++;
            return 1'b0;
        end

        lim = (limit_cnt == 0) ? 1 : limit_cnt;
        idx = match_count - skip_cnt;
        hit.last = (idx + 1 >= lim);
        if (match_count != {wbps_pkg::SEEN_W{1'b1}}) match_count++;
        if (hit.last) scan_done = 1'b1;
        hit.addr = it.addr - wbps_pkg::ADDR_W'(pat_len) + 48'd1;
        hit.idx  = idx[15:0];
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: bursts of random length separated by random gaps, some of them empty
    byte_item_t nxt;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                nxt = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.addr, nxt.data};
                s_tuser  <= nxt.start;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall pattern plus one long hold-off
    logic [7:0] rx_tick        = '0;
    int         hold_left      = 0;
    logic       long_hold_done = 1'b0;
    int         taken          = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready       <= 1'b0;
            rx_tick        <= '0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
            taken          <= 0;
        end else begin
            rx_tick <= rx_tick + 8'd1;
            if (m_tvalid && m_tready) taken <= taken + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!long_hold_done && taken >= 30 && m_tvalid && s_tvalid) begin
                // back up the result so the input side has to stall
                hold_left      <= 300;
                long_hold_done <= 1'b1;
                m_tready       <= 1'b0;
            end else begin
                case (rx_tick[7:6])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_tick[0];
                endcase
            end
        end
    end

    // Monitor: check result transfers, predict on input transfers
    match_t want;
    match_t hit;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (match_q.size() == 0) begin
                    $display("%0t: unexpected match, expected none, actual addr %h index %0d",
                             $time, m_tdata[47:0], m_tdata[63:48]);
                    errors++;
                end else begin
                    want = match_q.pop_front();
                    check_field("match_address", 64'(want.addr), 64'(m_tdata[47:0]));
                    check_field("match_index", 64'(want.idx), 64'(m_tdata[63:48]));
                    check_field("limit_reached", 64'(want.last), 64'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_in++;
                if (scan_byte(byte_item_t'{start: s_tuser, addr: s_tdata[55:8],
                                           data: s_tdata[7:0]}, hit))
                    match_q.insert(match_q.size(), hit);
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            wbps_pkg::REG_PATTERN_LOW:  pat_lo    = val;
            wbps_pkg::REG_PATTERN_HIGH: pat_hi    = val;
            wbps_pkg::REG_WILDCARD:     wild_mask = val[15:0];
            wbps_pkg::REG_LENGTH:       pat_len   = val[4:0];
            wbps_pkg::REG_SKIP:         skip_cnt  = val[15:0];
            wbps_pkg::REG_LIMIT:        limit_cnt = val[15:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
    endtask

    // Pause the sender until all results are in and the pipe has drained
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || match_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        settings++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic rs);
        pending_q.insert(pending_q.size(), byte_item_t'{start: rs, addr: next_addr, data: b});
        next_addr = next_addr + 48'd1;
    endtask

    // Random stream built around the current pattern: copies (some damaged or
    // cut by a region start) mixed with filler that shares pattern bytes
    task automatic queue_stream(input int count);
        int          made;
        int          plen;
        int          k;
        int          run;
        int          broken_pos;
        int          split_pos;
        logic [7:0]  b;
        made = 0;
        plen = (pat_len == 0 || pat_len > wbps_pkg::USABLE_LEN) ? 6 : pat_len;
        while (made < count) begin
            if ($urandom_range(0, 9) < 4) begin
                broken_pos = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, plen - 1)) : -1;
                split_pos  = (plen > 1 && $urandom_range(0, 7) == 0) ?
                             int'($urandom_range(1, plen - 1)) : -1;
                for (k = 0; k < plen; k++) begin
                    b = wild_mask[k] ? 8'($urandom) : pat_byte(k);
                    if (k == broken_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
                    push_byte(b, (k == split_pos) || ($urandom_range(0, 59) == 0));
                end
                made += plen;
            end else begin
                run = $urandom_range(1, 6);
                for (k = 0; k < run; k++) begin
                    b = $urandom_range(0, 1) ? 8'($urandom) : pat_byte($urandom_range(0, plen - 1));
                    push_byte(b, $urandom_range(0, 39) == 0);
                end
                made += run;
            end
        end
    endtask

    initial begin
        int ph;
        int k;
        logic [15:0] m;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 4-byte pattern 00 FF ?? 7F, wildcard at position 2
        wait_idle();
        reg_write(wbps_pkg::REG_LIMIT, 64'd65535);
        reg_write(wbps_pkg::REG_SKIP, 64'd0);
        reg_write(wbps_pkg::REG_PATTERN_LOW, 64'h0000_0000_7F80_FF00);
        reg_write(wbps_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(wbps_pkg::REG_WILDCARD, 64'h0004);
        reg_write(wbps_pkg::REG_LENGTH, 64'd4);
        // match straddling the top of the address space
        next_addr = 48'hFFFF_FFFF_FFFE;
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h7F, 1'b0);
        // region start inside the pattern: no match
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h7F, 1'b0);
        // last byte off by one: no match
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7E, 1'b0);

        // Directed: full 16-byte window of wildcards, two overlapping matches
        wait_idle();
        reg_write(wbps_pkg::REG_WILDCARD, 64'hFFFF);
        reg_write(wbps_pkg::REG_LENGTH, 64'd16);
        next_addr = '0;
        for (k = 0; k < 17; k++) push_byte((k % 2) ? 8'hFF : 8'h00, k == 0);

        // Random settings
        for (ph = 0; ph < 12; ph++) begin
            wait_idle();
            reg_write(wbps_pkg::REG_PATTERN_LOW, {$urandom, $urandom});
            reg_write(wbps_pkg::REG_PATTERN_HIGH, {$urandom, $urandom});
            case (ph % 4)
                0: m = 16'h0000;
                1: m = 16'($urandom & $urandom);
                2: m = 16'($urandom);
                default: m = (ph == 3) ? 16'hFFFF : 16'($urandom & $urandom & $urandom);
            endcase
            reg_write(wbps_pkg::REG_WILDCARD, 64'(m));
            if (ph == 5)
                reg_write(wbps_pkg::REG_LENGTH, 64'd0);
            else if (ph == 8)
                reg_write(wbps_pkg::REG_LENGTH, 64'($urandom_range(17, 31)));
            else if (ph == 2)
                reg_write(wbps_pkg::REG_LENGTH, 64'd1);
            else if (ph == 6)
                reg_write(wbps_pkg::REG_LENGTH, 64'd16);
            else
                reg_write(wbps_pkg::REG_LENGTH, 64'($urandom_range(1, 16)));
            if (ph == 9)
                reg_write(wbps_pkg::REG_SKIP, 64'd65535);
            else if (ph % 3 == 1)
                reg_write(wbps_pkg::REG_SKIP, 64'(match_count) + 64'($urandom_range(1, 6)));
            else
                reg_write(wbps_pkg::REG_SKIP, 64'd0);
            reg_write(wbps_pkg::REG_LIMIT,
                      (ph == 0) ? 64'd65535 : 64'($urandom_range(4096, 65535)));
            if (ph == 7) begin
                reg_write(REG_SPARE_A, {$urandom, $urandom});
                reg_write(REG_SPARE_B, {$urandom, $urandom});
            end
            case ($urandom_range(0, 3))
                0: next_addr = 48'hFFFF_FFFF_FFF0 + 48'($urandom_range(0, 15));
                1: next_addr = 48'($urandom_range(0, 15));
                default: next_addr = {$urandom, $urandom};
            endcase
            queue_stream(55);
        end

        // Zero limit acts as one: two skipped, one final report, then stopped
        wait_idle();
        reg_write(wbps_pkg::REG_SKIP, 64'(match_count) + 64'd2);
        reg_write(wbps_pkg::REG_LIMIT, 64'd0);
        reg_write(wbps_pkg::REG_WILDCARD, 64'h0001);
        reg_write(wbps_pkg::REG_LENGTH, 64'd1);
        next_addr = {$urandom, $urandom};
        for (k = 0; k < 10; k++) push_byte(8'($urandom), $urandom_range(0, 3) == 0);

        // Drain
        @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid) @(negedge aclk);
        for (k = 0; k < 1000 && match_q.size() != 0; k++) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (match_q.size() != 0) begin
            $display("%0t: %0d expected matches never arrived", $time, match_q.size());
            errors += match_q.size();
        end

        $display("tb: %0d bytes over %0d pattern settings, %0d matches checked, %0d reg writes",
                 bytes_in, settings, results_seen, cfg_writes);
        $display("tb: wildcards, region splits, address wrap, skip, limit stop and backpressure");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
